>>> hdl/bxds_pkg.sv
package bxds_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_FACTOR = 16;
    localparam int HEIGHT_LIMIT   = 2048;

    localparam int SCALE_W  = 5;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 12;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCALE_W-1:0]  SCALE_RST  = 5'd2;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_in_pix;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       end_of_row;
        logic       end_of_image;
    } t_out_pix;

endpackage

>>> hdl/box_average_downscale_top.sv
// path: at factor 1 an input beat goes through stage 1 to the output register; a block's
//   last pixel goes through stage 1 and the shared restoring divider to the output register
// throughput: 1 pixel per cycle without receiver stalls; a block-ending pixel holds the
//   divider until its result is output, so another block end meanwhile stalls the input
// reset (synchronous, active low) clears the position counters, the pipeline and the
//   registers to factor 2, 640 x 480; the column-sum store is not cleared and needs no pass
module box_average_downscale_top
    import bxds_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_pix              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_pix             o_out_data
);

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(HEIGHT_LIMIT + 1);
    localparam int AW    = $clog2(MAX_WIDTH / 2);
    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int SW    = 8 + $clog2(MAX_FACTOR * MAX_FACTOR);
    localparam int DW    = 2 * FW;
    localparam int DSW   = DW + 7;
    localparam int RMW   = (SW > DSW) ? SW : DSW;
    localparam int XW    = ((CW > RW) ? CW : RW) + FW + 2;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } t_div_st;

    typedef logic [3:0][SW-1:0] t_sums;

    // configuration registers
    logic [SCALE_W-1:0]  r_scale;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // effective (clamped) geometry
    logic [FW-1:0] w_f;
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;

    always_comb begin
        if (r_scale == '0) begin
            w_f = FW'(1);
        end else if (int'(r_scale) > MAX_FACTOR) begin
            w_f = FW'(MAX_FACTOR);
        end else begin
            w_f = FW'(r_scale);
        end
        if (r_width == '0) begin
            w_w = CW'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_w = CW'(MAX_WIDTH);
        end else begin
            w_w = CW'(r_width);
        end
        if (r_height == '0) begin
            w_h = RW'(1);
        end else if (int'(r_height) > HEIGHT_LIMIT) begin
            w_h = RW'(HEIGHT_LIMIT);
        end else begin
            w_h = RW'(r_height);
        end
    end

    // position counters: pixel position, position in block, block index and block origin
    logic [CW-1:0] r_col, r_bidx, r_bcol;
    logic [RW-1:0] r_row, r_brow;
    logic [FW-1:0] r_cib, r_rib;

    // stage 1: pixel waiting for its read data
    logic          r_s1_valid, r_s1_pass, r_s1_first, r_s1_last;
    logic          r_s1_eor, r_s1_eoi, r_s1_fwd;
    logic [AW-1:0] r_s1_idx;
    t_in_pix       r_s1_px;

    // line store and write-back forwarding
    t_sums         r_mem [DEPTH];
    t_sums         r_mem_q;
    t_sums         r_wb_sum;
    logic [AW-1:0] r_wb_idx;

    // shared divider
    t_div_st               r_div_st;
    logic [3:0][SW-1:0]    r_rem;
    logic [3:0][7:0]       r_q;
    logic [DSW-1:0]        r_dsh;
    logic [DW-1:0]         r_dvs;
    logic [2:0]            r_dcnt;
    logic                  r_div_eor, r_div_eoi;

    // output register
    logic     r_out_valid;
    t_out_pix r_out;

    // decode of the incoming pixel against the counters
    logic          w_pass, w_inside, w_first, w_last, w_eor, w_eoi;
    logic [XW-1:0] w_f_x, w_w_x, w_h_x;

    always_comb begin
        w_f_x    = XW'(w_f);
        w_w_x    = XW'(w_w);
        w_h_x    = XW'(w_h);
        w_pass   = (w_f == FW'(1));
        w_inside = !w_pass && (XW'(r_bcol) + w_f_x <= w_w_x)
                           && (XW'(r_brow) + w_f_x <= w_h_x);
        w_first  = (r_cib == '0) && (r_rib == '0);
        w_last   = (XW'(r_cib) + 1 == w_f_x) && (XW'(r_rib) + 1 == w_f_x);
        if (w_pass) begin
            w_eor = (XW'(r_col) + 1 == w_w_x);
            w_eoi = w_eor && (XW'(r_row) + 1 == w_h_x);
        end else begin
            // last whole block column / row when one more block would not fit
            w_eor = (XW'(r_bcol) + 2 * w_f_x > w_w_x);
            w_eoi = w_eor && (XW'(r_brow) + 2 * w_f_x > w_h_x);
        end
    end

    // stage 1 arithmetic
    t_sums w_base, w_sum;
    logic [3:0][7:0] w_px;

    always_comb begin
        w_px   = r_s1_px;
        w_base = r_s1_fwd ? r_wb_sum : r_mem_q;
        for (int c = 0; c < 4; c++) begin
            w_sum[c] = r_s1_first ? SW'(w_px[c]) : w_base[c] + SW'(w_px[c]);
        end
    end

    // flow control
    logic w_div_idle, w_out_free, w_s1_adv, w_mem_we, w_div_load, w_pass_out, w_accept;

    always_comb begin
        w_div_idle = (r_div_st == DIV_IDLE);
        w_out_free = !r_out_valid || !i_out_stall;
        if (!r_s1_valid) begin
            w_s1_adv = 1'b1;
        end else if (r_s1_pass) begin
            w_s1_adv = w_out_free && w_div_idle;
        end else begin
            w_s1_adv = !r_s1_last || w_div_idle;
        end
        w_mem_we   = r_s1_valid && !r_s1_pass && w_s1_adv;
        w_div_load = w_mem_we && r_s1_last;
        w_pass_out = r_s1_valid && r_s1_pass && w_s1_adv;
        w_accept   = i_in_valid && w_s1_adv;
    end

    assign o_in_stall  = !w_s1_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration and counters
    logic          w_cwrap, w_rend, w_rwrap, w_iend;
    logic [AW-1:0] w_idx;

    always_comb begin
        w_cwrap = (XW'(r_cib) + 1 >= w_f_x);
        w_rend  = (XW'(r_col) + 1 >= w_w_x);
        w_rwrap = (XW'(r_rib) + 1 >= w_f_x);
        w_iend  = (XW'(r_row) + 1 >= w_h_x);
        w_idx   = r_bidx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col <= '0; r_row <= '0; r_cib <= '0; r_rib <= '0;
            r_bidx <= '0; r_bcol <= '0; r_brow <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE: begin
                    r_scale <= i_cfg_data[SCALE_W-1:0];
                end
                CFG_WIDTH: begin
                    r_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_HEIGHT: begin
                    r_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
            // any known register write restarts the image
            if (i_cfg_idx == CFG_SCALE || i_cfg_idx == CFG_WIDTH
                    || i_cfg_idx == CFG_HEIGHT) begin
                r_col <= '0; r_row <= '0; r_cib <= '0; r_rib <= '0;
                r_bidx <= '0; r_bcol <= '0; r_brow <= '0;
            end
        end else if (w_accept) begin
            if (w_rend) begin
                r_col  <= '0;
                r_cib  <= '0;
                r_bidx <= '0;
                r_bcol <= '0;
                if (w_iend) begin
                    r_row  <= '0;
                    r_rib  <= '0;
                    r_brow <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                    if (w_rwrap) begin
                        r_rib  <= '0;
                        r_brow <= r_brow + RW'(w_f);
                    end else begin
                        r_rib <= r_rib + FW'(1);
                    end
                end
            end else begin
                r_col <= r_col + CW'(1);
                if (w_cwrap) begin
                    r_cib  <= '0;
                    r_bidx <= r_bidx + CW'(1);
                    r_bcol <= r_bcol + CW'(w_f);
                end else begin
                    r_cib <= r_cib + FW'(1);
                end
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_s1_valid <= w_accept && (w_pass || w_inside);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pass  <= w_pass;
            r_s1_first <= w_first;
            r_s1_last  <= w_last;
            r_s1_eor   <= w_eor;
            r_s1_eoi   <= w_eoi;
            r_s1_idx   <= w_idx;
            r_s1_px    <= i_in_data;
            // the entry being written this edge was read stale
            r_s1_fwd   <= w_mem_we && (r_s1_idx == w_idx);
        end
    end

    // line store: read-modify-write with a registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_s1_idx] <= w_sum;
        end
        if (w_accept) begin
            r_mem_q <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_wb_sum <= w_sum;
            r_wb_idx <= r_s1_idx;
        end
    end

    // divider: sum / (f*f), quotient fits 8 bits, one quotient bit per cycle
    logic [DW-1:0] w_dvs;
    assign w_dvs = DW'(w_f) * DW'(w_f);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_st <= DIV_IDLE;
        end else begin
            case (r_div_st)
                DIV_IDLE: begin
                    if (w_div_load) begin
                        r_div_st <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    if (r_dcnt == '0) begin
                        r_div_st <= DIV_DONE;
                    end
                end
                DIV_DONE: begin
                    if (w_out_free) begin
                        r_div_st <= DIV_IDLE;
                    end
                end
                default: begin
                    r_div_st <= DIV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_load) begin
            r_rem     <= w_sum;
            r_q       <= '0;
            r_dvs     <= w_dvs;
            r_dsh     <= DSW'(w_dvs) << 7;
            r_dcnt    <= 3'd7;
            r_div_eor <= r_s1_eor;
            r_div_eoi <= r_s1_eoi;
        end else if (r_div_st == DIV_RUN) begin
            for (int c = 0; c < 4; c++) begin
                if (RMW'(r_rem[c]) >= RMW'(r_dsh)) begin
                    r_rem[c] <= SW'(RMW'(r_rem[c]) - RMW'(r_dsh));
                    r_q[c]   <= {r_q[c][6:0], 1'b1};
                end else begin
                    r_q[c]   <= {r_q[c][6:0], 1'b0};
                end
            end
            r_dsh  <= r_dsh >> 1;
            r_dcnt <= r_dcnt - 3'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_div_st == DIV_DONE && w_out_free) || w_pass_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_st == DIV_DONE && w_out_free) begin
            r_out <= {r_q[3], r_q[2], r_q[1], r_q[0], r_div_eor, r_div_eoi};
        end else if (w_pass_out) begin
            r_out <= {r_s1_px, r_s1_eor, r_s1_eoi};
        end
    end

    // forwarded data must belong to the entry this pixel updates
    a_fwd_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_pass && r_s1_fwd && !r_s1_first) |-> (r_wb_idx == r_s1_idx))
        else $error("forwarded sum from another column");

    // pass-through and divider never compete for the output register
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pass_out |-> (r_div_st == DIV_IDLE))
        else $error("pass-through beat while divider busy");

    // a finished division leaves a remainder below the divisor (checked on channels 0 and 3)
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_st == DIV_DONE) |-> (RMW'(r_rem[0]) < RMW'(r_dvs)
                                    && RMW'(r_rem[3]) < RMW'(r_dvs)))
        else $error("divider remainder out of range");

    // the divider runs in the cycle after it is loaded
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_load |=> (r_div_st == DIV_RUN && r_dcnt == 3'd7))
        else $error("divider did not start");

endmodule

>>> test/testbench.sv
module testbench;
    import bxds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_pix              i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_pix             o_out_data;

    box_average_downscale_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // predictor copy of the registers and counters
    logic [SCALE_W-1:0]  cur_factor;
    logic [WIDTH_W-1:0]  cur_width;
    logic [HEIGHT_W-1:0] cur_height;
    int unsigned col_sum [1024][4];
    int unsigned src_col, src_row, blk_col, blk_row;

    t_in_pix  pixel_queue[$];
    t_out_pix avg_queue[$];
    int       n_errors;
    bit       quiet;       // no idling in the last part
    bit       hold_long;   // receiver holds off for a long stretch
    int       in_gap, out_gap, hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Some tests failed");
        $finish;
    end

    // predicted effect of a register write
    function automatic void predict_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
        if (idx == CFG_SCALE) cur_factor = val[SCALE_W-1:0];
        else if (idx == CFG_WIDTH) cur_width = val;
        else if (idx == CFG_HEIGHT) cur_height = val;
        else return;
        src_col = 0; src_row = 0; blk_col = 0; blk_row = 0;
    endfunction

    // box average of one pixel; pushes an output when a block completes or, at factor 1, for every pixel
    function automatic void predict_pixel(input t_in_pix p);
        int unsigned f, w, h, oc, orow, idx, c;
        int unsigned px[4];
        t_out_pix o;
        f = cur_factor; w = cur_width; h = cur_height;
        if (f < 1) f = 1;
        if (f > 16) f = 16;
        if (w < 1) w = 1;
        if (w > 2048) w = 2048;
        if (h < 1) h = 1;
        if (h > 2048) h = 2048;
        oc = w / f; orow = h / f;
        px[0] = p.in_red; px[1] = p.in_green; px[2] = p.in_blue; px[3] = p.in_alpha;
        if (f == 1) begin
            o.out_red = p.in_red; o.out_green = p.in_green;
            o.out_blue = p.in_blue; o.out_alpha = p.in_alpha;
            o.end_of_row = (src_col == w - 1);
            o.end_of_image = o.end_of_row && (src_row == h - 1);
            avg_queue.push_back(o);
        end else if (src_col < oc * f && src_row < orow * f) begin
            idx = src_col / f;
            if (idx < 1024) begin
                for (c = 0; c < 4; c++) begin
                    if (blk_col == 0 && blk_row == 0) col_sum[idx][c] = px[c];
                    else col_sum[idx][c] += px[c];
                end
                if (blk_col == f - 1 && blk_row == f - 1) begin
                    o.out_red   = 8'(col_sum[idx][0] / (f * f));
                    o.out_green = 8'(col_sum[idx][1] / (f * f));
                    o.out_blue  = 8'(col_sum[idx][2] / (f * f));
                    o.out_alpha = 8'(col_sum[idx][3] / (f * f));
                    o.end_of_row = (idx == oc - 1);
                    o.end_of_image = o.end_of_row && (src_row / f == orow - 1);
                    avg_queue.push_back(o);
                end
            end
        end
        blk_col++;
        if (blk_col >= f) blk_col = 0;
        src_col++;
        if (src_col >= w) begin
            src_col = 0; blk_col = 0;
            blk_row++;
            if (blk_row >= f) blk_row = 0;
            src_row++;
            if (src_row >= h) begin
                src_row = 0; blk_row = 0;
            end
        end
    endfunction

    function automatic t_in_pix rand_pixel();
        t_in_pix p;
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            default: p = $urandom;
        endcase
        return p;
    endfunction

    // driver: one pending pixel at a time, bursts of idle cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            // the beat on the bus was taken at this edge
            if (i_in_valid) void'(pixel_queue.pop_front());
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    in_gap <= $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pixel_queue[0];
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // predict on accepted input beats
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) predict_pixel(i_in_data);
    end

    // receiver stall bursts and the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap <= 0;
            hold_cnt <= 0;
        end else if (hold_long && hold_cnt < 300) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap <= $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: compare each output beat with the oldest predicted average
    always @(posedge i_clk) begin
        t_out_pix e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (avg_queue.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, o_out_data);
                n_errors++;
            end else begin
                e = avg_queue.pop_front();
                if (o_out_data !== e) begin
                    $display("%0t: mismatch expected %h actual %h", $time, e, o_out_data);
                    n_errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pixel_queue.size() > 0 || avg_queue.size() > 0) && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("Some tests failed");
            $finish;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        predict_cfg(idx, CFG_W'(val));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_image(input int f, input int w, input int h);
        write_cfg(CFG_SCALE, f);
        write_cfg(CFG_WIDTH, w);
        write_cfg(CFG_HEIGHT, h);
    endtask

    task automatic queue_pixels(input int n);
        repeat (n) pixel_queue.push_back(rand_pixel());
    endtask

    initial begin
        int k, f, w, h;
        n_errors = 0; quiet = 0; hold_long = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_SCALE; i_cfg_data = '0;
        i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        cur_factor = SCALE_RST; cur_width = WIDTH_RST; cur_height = HEIGHT_RST;
        src_col = 0; src_row = 0; blk_col = 0; blk_row = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry, a few pixels of the first row
        repeat (4) pixel_queue.push_back('1);
        repeat (4) pixel_queue.push_back('0);
        wait_idle();
        // pass through, saturated block of all ones
        set_image(1, 3, 2);
        queue_pixels(6);
        wait_idle();
        set_image(2, 2, 2);
        repeat (4) pixel_queue.push_back('1);
        wait_idle();
        // factor zero acts as one, zero sizes act as one
        set_image(0, 0, 0);
        queue_pixels(3);
        wait_idle();
        // image smaller than one block: no output
        set_image(4, 3, 3);
        queue_pixels(9);
        wait_idle();
        // factor above the limit saturates, oversized width saturates
        set_image(31, 4095, 4095);
        wait_idle();

        // random images, mostly small, fully streamed
        for (k = 0; k < 24; k++) begin
            if (k == 20) quiet = 1;
            f = $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 4);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            if (k == 3) begin f = 16; w = 33; h = 17; end
            if (k == 5) begin f = 2; w = 80; h = 4; end
            set_image(f, w, h);
            if (k == 5) hold_long = 1;
            if (k == 3 || k == 5) begin
                queue_pixels(w * h);
            end else begin
                queue_pixels(w * h * $urandom_range(1, 2) + $urandom_range(0, 3));
            end
            wait_idle();
        end
        // saturated height and width with a short stream
        set_image(3, 4095, 4095);
        queue_pixels(40);
        wait_idle();

        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/bxds_pkg.sv
hdl/box_average_downscale_top.sv
test/testbench.sv
